>>> sv/sorted_set_engine_core_assert.svh
// Assertion macros for the sorted set engine.
// Expects aclk and aresetn in the scope of each use.
`ifndef SORTED_SET_ENGINE_CORE_ASSERT_SVH
`define SORTED_SET_ENGINE_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SSE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sse_pkg.sv
// Shared constants, codes and types of the sorted set engine.
// No dependencies.
package sse_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_ERASE    = 2'd1;
    localparam logic [1:0] ACT_CONTAINS = 2'd2;
    localparam logic [1:0] ACT_GET      = 2'd3;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef struct packed {
        logic   ins;
        logic   ers;
        value_t key;
    } cell_ctrl_t;

    typedef struct packed {
        value_t entry;
        logic   ge;
    } cell_link_t;

endpackage

>>> sv/sse_cell.sv
// One slot of the sorted row: holds an entry, compares it with the key
// and shifts toward either neighbor on insert or erase. Depends on sse_pkg.
module sse_cell (
    input  logic                aclk,
    input  sse_pkg::cell_ctrl_t ctrl,
    input  logic                cell_valid,
    input  sse_pkg::cell_link_t left_link,
    input  sse_pkg::value_t     right_entry,
    output sse_pkg::cell_link_t link_out,
    output logic                hit
);

    sse_pkg::value_t entry_reg;
    sse_pkg::value_t entry_next;
    logic            ge;

    assign ge  = !(cell_valid && (entry_reg < ctrl.key));
    assign hit = cell_valid && (entry_reg == ctrl.key);

    assign link_out.entry = entry_reg;
    assign link_out.ge    = ge;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && ge) begin
            entry_next = left_link.ge ? left_link.entry : ctrl.key;
        end else if (ctrl.ers && ge) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> sv/sorted_set_engine_core.sv
// Top level of the sorted set engine: request channel, row of cells,
// result register. Depends on sse_pkg, sse_cell and the assertion header.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the action (insert,
//   erase, contains, get by rank), s_tdata the key and the rank. Each
//   request yields exactly one result on the m_ channel: m_tuser carries
//   the success flag, m_tdata the found value and the entry count.
//   Every cell of the row compares its entry with the key in the same
//   cycle and shifts toward its neighbor on insert or erase, so a request
//   is done in the cycle it is accepted. m_tvalid rises in the cycle after
//   acceptance; throughput is one transaction per cycle while m_tready is high.
//   The result register holds a transaction while m_tready is low; a new
//   request is taken in the same cycle the held result leaves, so a
//   stalled receiver stalls the s_ channel and nothing is lost.
//   Reset (aresetn low at a clock edge) empties the set and drops any
//   pending result; the entry cells need no clearing.
`include "sorted_set_engine_core_assert.svh"

module sorted_set_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_value [31:0], rank [35:32], zero [39:36]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // found_value [31:0], entry_count [36:32], zero [39:37]
    output logic [0:0]  m_tuser    // ok [0]
);

    localparam int N = sse_pkg::CAPACITY;

    sse_pkg::cell_ctrl_t ctrl;
    sse_pkg::cell_link_t links [N];
    sse_pkg::value_t     entries [N];
    logic [N-1:0]        hits;
    logic [N-1:0]        valids;

    sse_pkg::count_t count_reg;
    sse_pkg::count_t count_next;
    logic            m_valid_reg;
    logic            ok_reg;
    logic            ok_next;
    logic [31:0]     value_reg;
    logic [31:0]     value_next;
    sse_pkg::count_t out_count_reg;

    logic            accept;
    logic            present;
    logic [1:0]      action;
    logic [3:0]      rank;
    sse_pkg::value_t key;
    logic            not_full;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign action   = s_tuser;
    assign rank     = s_tdata[35:32];
    assign key      = sse_pkg::value_t'(s_tdata[31:0]);
    assign present  = |hits;
    assign not_full = count_reg < sse_pkg::count_t'(N);

    assign ctrl.key = key;
    assign ctrl.ins = accept && (action == sse_pkg::ACT_INSERT) && !present && not_full;
    assign ctrl.ers = accept && (action == sse_pkg::ACT_ERASE) && present;

    for (genvar i = 0; i < N; i++) begin : g_cell
        sse_pkg::cell_link_t left_link;
        sse_pkg::value_t     right_entry;

        assign valids[i] = count_reg > sse_pkg::count_t'(i);
        assign entries[i] = links[i].entry;

        if (i == 0) begin : g_first
            assign left_link.entry = links[i].entry;
            assign left_link.ge    = 1'b0;
        end else begin : g_mid
            assign left_link = links[i-1];
        end

        if (i == N - 1) begin : g_last
            assign right_entry = links[i].entry;
        end else begin : g_inner
            assign right_entry = links[i+1].entry;
        end

        sse_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_valid  (valids[i]),
            .left_link   (left_link),
            .right_entry (right_entry),
            .link_out    (links[i]),
            .hit         (hits[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        ok_next    = 1'b0;
        value_next = '0;
        unique case (action)
            sse_pkg::ACT_INSERT: begin
                ok_next = ctrl.ins;
                if (ctrl.ins) begin
                    count_next = count_reg + sse_pkg::count_t'(1);
                end
            end
            sse_pkg::ACT_ERASE: begin
                ok_next = ctrl.ers;
                if (ctrl.ers) begin
                    count_next = count_reg - sse_pkg::count_t'(1);
                end
            end
            sse_pkg::ACT_CONTAINS: begin
                ok_next = present;
            end
            sse_pkg::ACT_GET: begin
                if (sse_pkg::count_t'(rank) < count_reg) begin
                    ok_next    = 1'b1;
                    value_next = 32'(entries[sse_pkg::idx_t'(rank)]);
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg        <= ok_next;
            value_reg     <= value_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {3'b000, out_count_reg, value_reg};

    `SSE_ASSERT_ALWAYS(a_count_bound, count_reg <= sse_pkg::count_t'(N), "count above capacity")
    `SSE_ASSERT_NEXT(a_result_count, accept, m_tvalid && (out_count_reg == count_reg), "result count differs from stored count")
    `SSE_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_reg == $past(count_reg) + sse_pkg::count_t'(1), "insert did not grow the set")
    `SSE_ASSERT_NEXT(a_hold_count, !accept, $stable(count_reg), "count changed without a request")

endmodule
